// ----- rtl/arp_pkg.sv -----
// Shared types and constants for the ARP neighbour resolver.
`timescale 1ns / 1ps
package arp_pkg;
	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_RECV = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] FT_IPV4 = 2'd0;
	localparam logic [1:0] FT_ARP = 2'd1;
	localparam logic [1:0] AO_REQ = 2'd0;
	localparam logic [1:0] AO_REP = 2'd1;
	localparam logic [2:0] K_IPV4 = 3'd0;
	localparam logic [2:0] K_AREQ = 3'd1;
	localparam logic [2:0] K_AREP = 3'd2;
	localparam logic [2:0] K_UP = 3'd3;
	localparam logic [2:0] K_NONE = 3'd4;
	localparam logic [2:0] K_DROP = 3'd5;
	localparam logic [1:0] REG_MAC = 2'd0;
	localparam logic [1:0] REG_IP = 2'd1;
	localparam logic [1:0] REG_RTO = 2'd2;
	localparam logic [1:0] REG_MTO = 2'd3;
	localparam logic [15:0] RTO_RESET = 16'd5000;
	localparam logic [15:0] MTO_RESET = 16'd30000;
	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
	localparam int MAX_OUT = 8;

	// controller -> datapath commands
	typedef struct packed {
		logic start;     // latch input item and search tables
		logic decide;    // act on search results
		logic tick_step; // age one cache and one pending entry
		logic rel_step;  // emit one released handle
		logic rel_done;  // close the release
		logic out_load;  // present one result
	} arp_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic tick_done;
		logic rel_more;
		logic res_pending;
		logic res_last;
	} arp_sts_t;
endpackage

// ----- rtl/arp_ctrl.sv -----
// Controller sequencing lookup, ageing and release steps.
`timescale 1ns / 1ps
module arp_ctrl
	import arp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_slot_free,
	input  logic [1:0] op_q_in,
	input  arp_sts_t sts,
	output arp_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_TICK = 3'd2;
	localparam logic [2:0] S_REL = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (op_q_in == OP_TICK) begin
					state_d = S_TICK;
				end else begin
					cmd.decide = 1'b1;
					state_d = S_REL;
				end
			end
			S_TICK: begin
				cmd.tick_step = 1'b1;
				if (sts.tick_done) state_d = S_EMIT;
			end
			S_REL: begin
				if (sts.rel_more) begin
					if (out_slot_free) cmd.rel_step = 1'b1;
				end else begin
					cmd.rel_done = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!sts.res_pending) state_d = S_IDLE;
				else if (out_slot_free) begin
					cmd.out_load = 1'b1;
					if (sts.res_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// ----- rtl/arp_dp.sv -----
// Datapath: cache, pending table, handle queues and result staging.
`timescale 1ns / 1ps
module arp_dp
	import arp_pkg::*;
#(
	parameter int CACHE_ENTRIES = 16,
	parameter int PENDING_ENTRIES = 8,
	parameter int QUEUE_DEPTH = 8,
	parameter int HANDLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  arp_cmd_t cmd,
	output arp_sts_t sts,
	output logic [1:0] op_q_out,
	input  logic slot_free,
	input  logic [47:0] own_mac,
	input  logic [31:0] own_ip,
	input  logic [15:0] rto,
	input  logic [15:0] mto,
	input  logic [1:0] op,
	input  logic [31:0] next_hop_ip,
	input  logic [HANDLE_WIDTH-1:0] datagram_handle,
	input  logic [47:0] frame_dst_mac,
	input  logic [1:0] frame_type,
	input  logic parse_ok,
	input  logic [1:0] arp_opcode,
	input  logic [31:0] sender_ip,
	input  logic [47:0] sender_mac,
	input  logic [31:0] arp_target_ip_in,
	input  logic [15:0] elapsed_ms,
	// result slot
	output logic        res_valid,
	output logic [2:0]  res_kind,
	output logic [47:0] res_dst,
	output logic [31:0] res_tip,
	output logic [47:0] res_tmac,
	output logic [HANDLE_WIDTH-1:0] res_handle,
	output logic        res_last
);
	localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
	localparam int QN = PENDING_ENTRIES * QUEUE_DEPTH;
	localparam int QAW = (QN > 1) ? $clog2(QN) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam int RELMAX = (QUEUE_DEPTH < MAX_OUT) ? QUEUE_DEPTH : MAX_OUT;
	localparam int SW = (CW > PW) ? CW : PW;

	// tables
	logic [CACHE_ENTRIES-1:0] c_val_q;
	logic [31:0] c_ip_q [CACHE_ENTRIES];
	logic [47:0] c_mac_q [CACHE_ENTRIES];
	logic [15:0] c_age_q [CACHE_ENTRIES];
	logic [PENDING_ENTRIES-1:0] p_val_q, p_tmr_q;
	logic [31:0] p_ip_q [PENDING_ENTRIES];
	logic [15:0] p_age_q [PENDING_ENTRIES];
	logic [NW-1:0] p_cnt_q [PENDING_ENTRIES];
	logic [HANDLE_WIDTH-1:0] q_mem [QN];

	// latched item
	logic [1:0] op_q, ft_q, ao_q;
	logic [31:0] nip_q, sip_q, tip_q;
	logic [47:0] dmac_q, smac_q;
	logic [HANDLE_WIDTH-1:0] h_q;
	logic pok_q;
	logic [15:0] el_q;

	// pending results (up to two besides the release stream)
	logic r0_v_q, r1_v_q;
	logic [2:0] r0_k_q, r1_k_q;
	logic [47:0] r0_d_q, r0_m_q;
	logic [31:0] r0_t_q, r1_t_q;
	logic [HANDLE_WIDTH-1:0] r0_h_q, r1_h_q;
	logic any_q; // a result was already emitted, or a release is due, for this item

	// release / tick sweep
	logic [PW-1:0] rel_p_q;
	logic [NW-1:0] rel_n_q, rel_k_q;
	logic [47:0] rel_to_q;
	logic [SW:0] sw_q;

	assign op_q_out = op_q;

	// combinational search on latched keys
	logic ch, cf, ph, pf;
	logic [CW-1:0] ci, cfi;
	logic [PW-1:0] pi, pfi;
	logic [31:0] key;
	always_comb begin
		key = (op_q == OP_SEND) ? nip_q : sip_q;
		ch = 1'b0; cf = 1'b0; ci = '0; cfi = '0;
		for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
			if (c_val_q[i] && c_ip_q[i] == key) begin ch = 1'b1; ci = CW'(i); end
			if (!c_val_q[i]) begin cf = 1'b1; cfi = CW'(i); end
		end
		ph = 1'b0; pf = 1'b0; pi = '0; pfi = '0;
		for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
			if (p_val_q[i] && p_ip_q[i] == key) begin ph = 1'b1; pi = PW'(i); end
			if (!p_val_q[i]) begin pf = 1'b1; pfi = PW'(i); end
		end
	end

	logic for_us;
	assign for_us = (dmac_q == own_mac || dmac_q == MAC_BCAST) && pok_q;

	// queue addresses: slot base plus position
	logic [QAW-1:0] q_wr_hit, q_wr_new, q_rd;
	assign q_wr_hit = QAW'(pi) * QAW'(QUEUE_DEPTH) + QAW'(p_cnt_q[pi]);
	assign q_wr_new = QAW'(pfi) * QAW'(QUEUE_DEPTH);
	assign q_rd = QAW'(rel_p_q) * QAW'(QUEUE_DEPTH) + QAW'(rel_k_q);

	assign sts.rel_more = (rel_k_q < rel_n_q);
	assign sts.tick_done = (sw_q == (SW+1)'(((CACHE_ENTRIES > PENDING_ENTRIES)
		? CACHE_ENTRIES : PENDING_ENTRIES) - 1));
	assign sts.res_pending = r0_v_q || r1_v_q || !any_q;
	assign sts.res_last = r0_v_q ? !r1_v_q : 1'b1;

	logic [16:0] ca, pa;
	logic [CW-1:0] sc;
	logic [PW-1:0] sp;
	assign sc = sw_q[CW-1:0];
	assign sp = sw_q[PW-1:0];
	assign ca = {1'b0, c_age_q[sc]} + {1'b0, el_q};
	assign pa = {1'b0, p_age_q[sp]} + {1'b0, el_q};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= op; ft_q <= frame_type; ao_q <= arp_opcode;
			nip_q <= next_hop_ip; sip_q <= sender_ip; tip_q <= arp_target_ip_in;
			dmac_q <= frame_dst_mac; smac_q <= sender_mac; h_q <= datagram_handle;
			pok_q <= parse_ok; el_q <= elapsed_ms;
		end
		if (cmd.decide && op_q == OP_SEND && !ch) begin
			if (ph && p_tmr_q[pi] && p_cnt_q[pi] < NW'(QUEUE_DEPTH))
				q_mem[q_wr_hit] <= h_q;
			else if (!ph && pf)
				q_mem[q_wr_new] <= h_q;
			// timer restarts only when a fresh request goes out
			if (ph && !p_tmr_q[pi]) p_age_q[pi] <= '0;
			else if (!ph && pf) begin p_age_q[pfi] <= '0; p_ip_q[pfi] <= nip_q; end
		end
		if (cmd.decide && op_q == OP_RECV && for_us && ft_q == FT_ARP && !ch && cf) begin
			c_ip_q[cfi] <= sip_q; c_mac_q[cfi] <= smac_q; c_age_q[cfi] <= '0;
		end
		if (cmd.decide) begin
			rel_to_q <= ch ? c_mac_q[ci] : smac_q;
			rel_p_q <= pi;
		end
		if (cmd.tick_step) begin
			if (sw_q < (SW+1)'(CACHE_ENTRIES) && c_val_q[sc] && ca < {1'b0, mto})
				c_age_q[sc] <= ca[15:0];
			if (sw_q < (SW+1)'(PENDING_ENTRIES) && p_val_q[sp] && p_tmr_q[sp]
				&& pa < {1'b0, rto})
				p_age_q[sp] <= pa[15:0];
		end
		if (cmd.rel_step) res_handle <= q_mem[q_rd];
		else if (cmd.out_load) res_handle <= r0_v_q ? r0_h_q : (r1_v_q ? r1_h_q : '0);
		if (cmd.rel_step) begin
			res_kind <= K_IPV4; res_dst <= rel_to_q; res_tip <= '0; res_tmac <= '0;
			res_last <= (rel_k_q + NW'(1) == rel_n_q);
		end else if (cmd.out_load) begin
			if (r0_v_q) begin
				res_kind <= r0_k_q; res_dst <= r0_d_q; res_tip <= r0_t_q;
				res_tmac <= r0_m_q; res_last <= !r1_v_q;
			end else if (r1_v_q) begin
				res_kind <= r1_k_q; res_dst <= '0; res_tip <= r1_t_q;
				res_tmac <= '0; res_last <= 1'b1;
			end else begin
				res_kind <= K_NONE; res_dst <= '0; res_tip <= '0;
				res_tmac <= '0; res_last <= 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_val_q <= '0; p_val_q <= '0; p_tmr_q <= '0;
			for (int i = 0; i < PENDING_ENTRIES; i++) p_cnt_q[i] <= '0;
			r0_v_q <= 1'b0; r1_v_q <= 1'b0; any_q <= 1'b0;
			r0_k_q <= K_NONE; r1_k_q <= K_NONE;
			r0_d_q <= '0; r0_m_q <= '0; r0_t_q <= '0; r1_t_q <= '0;
			r0_h_q <= '0; r1_h_q <= '0;
			rel_n_q <= '0; rel_k_q <= '0; sw_q <= '0;
			res_valid <= 1'b0;
		end else begin
			// result held until taken
			res_valid <= cmd.rel_step || cmd.out_load || (res_valid && !slot_free);
			if (cmd.start) begin
				any_q <= 1'b0; sw_q <= '0;
				r0_v_q <= 1'b0; r1_v_q <= 1'b0;
				rel_n_q <= '0; rel_k_q <= '0;
			end
			if (cmd.rel_step) begin
				rel_k_q <= rel_k_q + NW'(1);
				any_q <= 1'b1;
			end
			if (cmd.rel_done && rel_n_q != '0) begin
				p_cnt_q[rel_p_q] <= '0;
				if (!p_tmr_q[rel_p_q]) p_val_q[rel_p_q] <= 1'b0;
			end
			if (cmd.out_load) begin
				any_q <= 1'b1;
				if (r0_v_q) r0_v_q <= 1'b0;
				else r1_v_q <= 1'b0;
			end
			if (cmd.tick_step) begin
				sw_q <= sw_q + (SW+1)'(1);
				if (sw_q < (SW+1)'(CACHE_ENTRIES) && c_val_q[sc] && ca >= {1'b0, mto})
					c_val_q[sc] <= 1'b0;
				if (sw_q < (SW+1)'(PENDING_ENTRIES) && p_val_q[sp] && p_tmr_q[sp]
					&& pa >= {1'b0, rto}) begin
					p_tmr_q[sp] <= 1'b0;
					if (p_cnt_q[sp] == '0) p_val_q[sp] <= 1'b0;
				end
			end
			if (cmd.decide) begin
				r0_d_q <= '0; r0_m_q <= '0; r0_t_q <= '0; r0_h_q <= '0;
				r1_t_q <= nip_q; r1_h_q <= h_q; r1_k_q <= K_DROP;
				unique case (op_q)
					OP_SEND: begin
						if (ch) begin
							r0_v_q <= 1'b1; r0_k_q <= K_IPV4;
							r0_d_q <= c_mac_q[ci]; r0_h_q <= h_q;
						end else if (ph && p_tmr_q[pi]) begin
							if (p_cnt_q[pi] < NW'(QUEUE_DEPTH)) begin
								p_cnt_q[pi] <= p_cnt_q[pi] + NW'(1);
								r0_v_q <= 1'b1; r0_k_q <= K_NONE;
							end else r1_v_q <= 1'b1;
						end else if (ph) begin
							r0_v_q <= 1'b1; r0_k_q <= K_AREQ; r0_d_q <= MAC_BCAST;
							r0_t_q <= nip_q; r1_v_q <= 1'b1;
							p_tmr_q[pi] <= 1'b1;
						end else if (!pf) begin
							r1_v_q <= 1'b1;
						end else begin
							r0_v_q <= 1'b1; r0_k_q <= K_AREQ; r0_d_q <= MAC_BCAST;
							r0_t_q <= nip_q;
							p_val_q[pfi] <= 1'b1; p_tmr_q[pfi] <= 1'b1;
							p_cnt_q[pfi] <= NW'(1);
						end
					end
					OP_RECV: begin
						if (for_us && ft_q == FT_IPV4) begin
							r0_v_q <= 1'b1; r0_k_q <= K_UP; r0_h_q <= h_q;
						end else if (for_us && ft_q == FT_ARP) begin
							if (!ch && cf) c_val_q[cfi] <= 1'b1;
							if (ao_q == AO_REQ && tip_q == own_ip) begin
								r0_v_q <= 1'b1; r0_k_q <= K_AREP; r0_d_q <= smac_q;
								r0_t_q <= sip_q; r0_m_q <= smac_q;
							end else if (ao_q == AO_REP && ph) begin
								rel_n_q <= (p_cnt_q[pi] > NW'(RELMAX))
									? NW'(RELMAX) : p_cnt_q[pi];
								if (p_cnt_q[pi] != '0) any_q <= 1'b1;
								else begin
									// empty queue: free the slot if its timer has stopped
									if (!p_tmr_q[pi]) p_val_q[pi] <= 1'b0;
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- rtl/arp_neighbor_resolver_top.sv -----
// Top level of the ARP neighbour resolver.
// Flow: an item is latched, the cache and pending table are searched, then the
// outcome is acted on; a tick instead sweeps every cache and pending entry.
// A new item is taken only once every result of the last one has been presented:
// up to two for a send, one per released handle for a reply; out_ready stalls hold it.
// Reset (arst_n low, asynchronous): tables emptied, config and control registers to defaults.
`timescale 1ns / 1ps
module arp_neighbor_resolver_top
	import arp_pkg::*;
#(
	parameter int CACHE_ENTRIES = 16,
	parameter int PENDING_ENTRIES = 8,
	parameter int QUEUE_DEPTH = 8,
	parameter int HANDLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [47:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] op,
	input  logic [31:0] next_hop_ip,
	input  logic [HANDLE_WIDTH-1:0] datagram_handle,
	input  logic [47:0] frame_dst_mac,
	input  logic [1:0] frame_type,
	input  logic parse_ok,
	input  logic [1:0] arp_opcode,
	input  logic [31:0] sender_ip,
	input  logic [47:0] sender_mac,
	input  logic [31:0] arp_target_ip_in,
	input  logic [15:0] elapsed_ms,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] kind,
	output logic [47:0] dst_mac,
	output logic [31:0] out_target_ip,
	output logic [47:0] out_target_mac,
	output logic [HANDLE_WIDTH-1:0] out_handle,
	output logic last
);
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic [15:0] rto_q, mto_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0; own_ip_q <= '0; rto_q <= RTO_RESET; mto_q <= MTO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAC: own_mac_q <= cfg_data;
				REG_IP:  own_ip_q <= cfg_data[31:0];
				REG_RTO: rto_q <= cfg_data[15:0];
				REG_MTO: mto_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	arp_cmd_t cmd;
	arp_sts_t sts;
	logic [1:0] op_q;
	logic res_valid, slot_free;

	// output slot frees when empty or being taken this cycle
	assign out_valid = res_valid;
	assign slot_free = !res_valid || out_ready;

	arp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_slot_free(slot_free), .op_q_in(op_q), .sts(sts), .cmd(cmd)
	);

	arp_dp #(
		.CACHE_ENTRIES(CACHE_ENTRIES), .PENDING_ENTRIES(PENDING_ENTRIES),
		.QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_WIDTH(HANDLE_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .op_q_out(op_q),
		.slot_free(slot_free),
		.own_mac(own_mac_q), .own_ip(own_ip_q), .rto(rto_q), .mto(mto_q),
		.op(op), .next_hop_ip(next_hop_ip), .datagram_handle(datagram_handle),
		.frame_dst_mac(frame_dst_mac), .frame_type(frame_type), .parse_ok(parse_ok),
		.arp_opcode(arp_opcode), .sender_ip(sender_ip), .sender_mac(sender_mac),
		.arp_target_ip_in(arp_target_ip_in), .elapsed_ms(elapsed_ms),
		.res_valid(res_valid), .res_kind(kind), .res_dst(dst_mac),
		.res_tip(out_target_ip), .res_tmac(out_target_mac),
		.res_handle(out_handle), .res_last(last)
	);

	// in_ready is low after every accepted item, so no two items are taken back to back
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind <= K_DROP))
		else $error("bad result kind");
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == K_AREQ) |-> (dst_mac == MAC_BCAST))
		else $error("request not broadcast");
endmodule
